@@ src/assert_macros.svh @@
// Assertion helpers, clocked on clk and held off while rst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMP(lbl, ante, cons, msg)
`define ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/ppos_pkg.sv @@
package ppos_pkg;

    localparam int MAX_WALLS_DEF = 64;
    localparam int COORD_W       = 12;
    localparam int WALL_W        = 4 * COORD_W;
    localparam int Q_W           = 21;
    localparam int IDX_W         = 6;
    localparam int COUNT_W       = 7;
    localparam int REACH_W       = 16;
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;

    localparam int DIV_NW = 64;
    localparam int DIV_DW = 41;
    localparam int DIV_QW = 24;
    localparam int SQRT_XW = 48;

    localparam logic REG_WALL_COUNT = 1'b0;
    localparam logic REG_REACH      = 1'b1;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef struct packed {
        logic shift;
        logic load;
    } ppos_cell_ctl_t;

    function automatic logic signed [Q_W-1:0] sat_q(input logic signed [25:0] v);
        logic signed [Q_W-1:0] r;
        if (v > 26'(Q_MAX))
            r = Q_MAX;
        else if (v < 26'(Q_MIN))
            r = Q_MIN;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

endpackage

@@ src/ppos_channels.sv @@
interface ppos_item_if import ppos_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [IDX_W-1:0]          wall_index;
    logic [COORD_W-1:0]        wall_start_x;
    logic [COORD_W-1:0]        wall_start_y;
    logic [COORD_W-1:0]        wall_end_x;
    logic [COORD_W-1:0]        wall_end_y;
    logic signed [Q_W-1:0]     point_x;
    logic signed [Q_W-1:0]     point_y;

    modport source (output valid, mode, wall_index, wall_start_x, wall_start_y,
                    wall_end_x, wall_end_y, point_x, point_y, input ready);
    modport sink (input valid, mode, wall_index, wall_start_x, wall_start_y,
                  wall_end_x, wall_end_y, point_x, point_y, output ready);
endinterface

interface ppos_result_if import ppos_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [Q_W-1:0]     placed_x;
    logic signed [Q_W-1:0]     placed_y;
    logic                      was_moved;

    modport source (output valid, placed_x, placed_y, was_moved, input ready);
    modport sink (input valid, placed_x, placed_y, was_moved, output ready);
endinterface

@@ src/ppos_cell.sv @@
module ppos_cell import ppos_pkg::*;
(
    input  logic               clk,
    input  ppos_cell_ctl_t     ctl,
    input  logic [WALL_W-1:0]  wr_data,
    input  logic [WALL_W-1:0]  shift_in,
    output logic [WALL_W-1:0]  wall
);

    logic [WALL_W-1:0] wall_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.load)
            wall_reg <= wr_data;
        else if (ctl.shift)
            wall_reg <= shift_in;
    end

    assign wall = wall_reg;

endmodule

@@ src/ppos_div.sv @@
module ppos_div import ppos_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int DW = DIV_DW,
    parameter int QW = DIV_QW
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] num,
    input  logic [DW-1:0] den,
    output logic          busy,
    output logic [QW-1:0] quo
);

    localparam int CW = (QW > 1) ? $clog2(QW) : 1;

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [QW-1:0] sh_reg;
    logic [DW:0]   trial;
    logic          ge;

    // numerator is known to give a quotient below 2^QW
    assign trial = {rem_reg, sh_reg[QW-1]};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(QW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= DW'(num[NW-1:QW]);
            sh_reg  <= num[QW-1:0];
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? DW'(trial - {1'b0, den_reg}) : trial[DW-1:0];
            sh_reg  <= {sh_reg[QW-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign quo  = sh_reg;

endmodule

@@ src/ppos_sqrt.sv @@
module ppos_sqrt import ppos_pkg::*;
#(
    parameter int XW = SQRT_XW
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [XW-1:0]   x,
    output logic            busy,
    output logic [XW/2-1:0] root
);

    localparam int RW = XW / 2;
    localparam int CW = (RW > 1) ? $clog2(RW) : 1;

    logic          busy_reg;
    logic [CW-1:0] cnt_reg;
    logic [XW-1:0] x_reg;
    logic [RW-1:0] root_reg;
    logic [RW+1:0] rem_reg;
    logic [RW+3:0] t;
    logic [RW+3:0] trial;
    logic          ge;

    assign t     = {rem_reg, x_reg[XW-1:XW-2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = t >= trial;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CW'(RW - 1);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= x;
            root_reg <= '0;
            rem_reg  <= '0;
        end
        else if (busy_reg)
        begin
            x_reg    <= {x_reg[XW-3:0], 2'b00};
            rem_reg  <= ge ? (RW+2)'(t - trial) : t[RW+1:0];
            root_reg <= {root_reg[RW-2:0], ge};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

@@ src/point_push_out_of_segments.sv @@
// channel  | dir | transaction
// items    | in  | mode 0: wall table write; mode 1: point to place
// results  | out | placed point and moved flag, one per mode-1 item
// apb      | in  | wall_count at 0x0, reach at 0x4
// Mode 0 writes one table slot. Mode 1 steps through every table slot and works each slot below
// wall_count as a visited wall; a visited wall that pushes the point off the foot also takes the 24-step root;
// the shared 24-step divider serves two divides per visited wall of nonzero length and two per such push.
// The wall table is a ring of cells rotated once around per placement.
// Reset clears control, outputs and wall_count, sets reach to 2560; walls are undefined until written.
// A finished result waits in the output register; a new transaction is taken meanwhile.
`include "assert_macros.svh"
module point_push_out_of_segments import ppos_pkg::*;
#(
    parameter int MAX_WALLS = MAX_WALLS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    ppos_item_if.sink          items,
    ppos_result_if.source      results,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int RW   = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
    localparam int CMPW = (RW > COUNT_W) ? RW : COUNT_W;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RR, ST_WALL, ST_D1, ST_D2, ST_L1, ST_L2, ST_PM0, ST_PM1, ST_PM2,
        ST_PDIV, ST_CLAMP, ST_DD0, ST_DD1, ST_DD2, ST_TEST, ST_SQRT, ST_QM, ST_QD,
        ST_QW, ST_NEXT, ST_DONE
    } state_t;

    state_t                 state_reg;
    logic [RW-1:0]          rot_reg;
    logic                   comp_reg;
    logic                   moved_reg;
    logic                   out_valid_reg;
    logic signed [Q_W-1:0]  out_x_reg;
    logic signed [Q_W-1:0]  out_y_reg;
    logic                   out_moved_reg;
    logic [COUNT_W-1:0]     wall_count_reg;
    logic [REACH_W-1:0]     reach_reg;

    logic signed [Q_W-1:0]  px_reg, py_reg;
    logic signed [51:0]     prod_reg, acc_reg;
    logic signed [42:0]     dot_reg;
    logic [40:0]            len2_reg;
    logic signed [23:0]     fx_reg, fy_reg;
    logic signed [24:0]     dx_reg, dy_reg;
    logic [50:0]            d2_reg;
    logic [31:0]            rr_reg;
    logic [23:0]            q_reg;
    logic [24:0]            k_reg;

    logic [WALL_W-1:0]      cell_q [MAX_WALLS];
    logic [WALL_W-1:0]      wr_data;
    logic                   wr_en, ring_shift, accept;

    logic [19:0]            sx, sy, ex, ey;
    logic signed [23:0]     sx24, sy24, ex24, ey24, cfx, cfy;
    logic signed [21:0]     ux, uy;
    logic signed [20:0]     vx, vy, vc;
    logic [20:0]            vc_abs;
    logic [42:0]            dot_neg;
    logic [41:0]            dot_abs;
    logic signed [24:0]     dx_c, dy_c, dc;
    logic [24:0]            dc_neg;
    logic [15:0]            dc_abs;
    logic signed [25:0]     mul_a, mul_b;
    logic signed [24:0]     s25, fq, fnew25;
    logic signed [25:0]     p26, pdelta, pnew26, preach26;
    logic                   div_start, div_busy, sqrt_start, sqrt_busy, pushed;
    logic [DIV_NW-1:0]      div_num;
    logic [DIV_DW-1:0]      div_den;
    logic [DIV_QW-1:0]      quo;
    logic [SQRT_XW/2-1:0]   root;

    assign accept       = items.valid && items.ready;
    assign items.ready  = (state_reg == ST_IDLE);
    assign wr_en        = accept && !items.mode;
    assign ring_shift   = (state_reg == ST_NEXT);
    assign wr_data      = {items.wall_end_y, items.wall_end_x,
                           items.wall_start_y, items.wall_start_x};

    for (genvar i = 0; i < MAX_WALLS; i++)
    begin : g_cell
        ppos_cell_ctl_t ctl;
        assign ctl.shift = ring_shift;
        assign ctl.load  = wr_en && (32'(items.wall_index) == 32'(i));
        ppos_cell u_cell
        (
            .clk      (clk),
            .ctl      (ctl),
            .wr_data  (wr_data),
            .shift_in (cell_q[(i + 1) % MAX_WALLS]),
            .wall     (cell_q[i])
        );
    end

    // head of the ring
    assign sx   = {cell_q[0][11:0], 8'd0};
    assign sy   = {cell_q[0][23:12], 8'd0};
    assign ex   = {cell_q[0][35:24], 8'd0};
    assign ey   = {cell_q[0][47:36], 8'd0};
    assign sx24 = signed'({4'd0, sx});
    assign sy24 = signed'({4'd0, sy});
    assign ex24 = signed'({4'd0, ex});
    assign ey24 = signed'({4'd0, ey});

    assign ux      = 22'(px_reg) - signed'({2'b00, sx});
    assign uy      = 22'(py_reg) - signed'({2'b00, sy});
    assign vx      = signed'({1'b0, ex}) - signed'({1'b0, sx});
    assign vy      = signed'({1'b0, ey}) - signed'({1'b0, sy});
    assign vc      = comp_reg ? vy : vx;
    assign vc_abs  = vc[20] ? 21'(-vc) : 21'(vc);
    assign dot_neg = 43'(-dot_reg);
    assign dot_abs = dot_reg[42] ? dot_neg[41:0] : dot_reg[41:0];

    // clamp of the foot, X rule before Y rule, ties to the end point
    always_comb
    begin
        cfx = fx_reg;
        cfy = fy_reg;
        if (fx_reg > sx24 && fx_reg > ex24)
        begin
            if (sx24 > ex24) begin cfx = sx24; cfy = sy24; end
            else begin cfx = ex24; cfy = ey24; end
        end
        else if (fx_reg < sx24 && fx_reg < ex24)
        begin
            if (sx24 < ex24) begin cfx = sx24; cfy = sy24; end
            else begin cfx = ex24; cfy = ey24; end
        end
        else if (fy_reg > sy24 && fy_reg > ey24)
        begin
            if (sy24 > ey24) begin cfx = sx24; cfy = sy24; end
            else begin cfx = ex24; cfy = ey24; end
        end
        else if (fy_reg < sy24 && fy_reg < ey24)
        begin
            if (sy24 < ey24) begin cfx = sx24; cfy = sy24; end
            else begin cfx = ex24; cfy = ey24; end
        end
    end

    assign dx_c   = 25'(px_reg) - 25'(cfx);
    assign dy_c   = 25'(py_reg) - 25'(cfy);
    assign dc     = comp_reg ? dy_reg : dx_reg;
    assign dc_neg = 25'(-dc);
    assign dc_abs = dc[24] ? dc_neg[15:0] : dc[15:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            ST_IDLE:  begin mul_a = signed'(26'(reach_reg)); mul_b = signed'(26'(reach_reg)); end
            ST_WALL:  begin mul_a = 26'(ux); mul_b = 26'(vx); end
            ST_D1:    begin mul_a = 26'(uy); mul_b = 26'(vy); end
            ST_D2:    begin mul_a = 26'(vx); mul_b = 26'(vx); end
            ST_L1:    begin mul_a = 26'(vy); mul_b = 26'(vy); end
            ST_PM0:   begin mul_a = signed'(26'(vc_abs)); mul_b = signed'(26'(dot_abs[20:0])); end
            ST_PM1:   begin mul_a = signed'(26'(vc_abs)); mul_b = signed'(26'(dot_abs[41:21])); end
            ST_DD0:   begin mul_a = 26'(dx_reg); mul_b = 26'(dx_reg); end
            ST_DD1:   begin mul_a = 26'(dy_reg); mul_b = 26'(dy_reg); end
            ST_QM:    begin mul_a = signed'(26'(dc_abs)); mul_b = signed'(26'(k_reg)); end
            default:  begin mul_a = '0; mul_b = '0; end
        endcase
    end

    assign div_start = (state_reg == ST_PM2) || (state_reg == ST_QD);
    assign div_num   = (state_reg == ST_PM2)
                     ? 64'($unsigned(acc_reg)) + (64'($unsigned(prod_reg)) << 21)
                       + 64'(len2_reg >> 1)
                     : 64'($unsigned(prod_reg)) + 64'(q_reg >> 1);
    assign div_den   = (state_reg == ST_PM2) ? len2_reg : DIV_DW'(q_reg);

    assign pushed     = d2_reg < 51'(rr_reg);
    assign sqrt_start = (state_reg == ST_TEST) && pushed && (d2_reg != '0);

    ppos_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(DIV_QW)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .busy  (div_busy),
        .quo   (quo)
    );

    ppos_sqrt #(.XW(SQRT_XW)) u_sqrt
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .x     ({d2_reg[31:0], 16'd0}),
        .busy  (sqrt_busy),
        .root  (root)
    );

    assign s25      = comp_reg ? signed'({5'd0, sy}) : signed'({5'd0, sx});
    assign fq       = signed'({1'b0, quo});
    assign fnew25   = (vc[20] ^ dot_reg[42]) ? s25 - fq : s25 + fq;
    assign p26      = comp_reg ? 26'(py_reg) : 26'(px_reg);
    assign pdelta   = signed'({2'b00, quo});
    assign pnew26   = dc[24] ? p26 - pdelta : p26 + pdelta;
    assign preach26 = 26'(px_reg) + signed'(26'(reach_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            rot_reg        <= '0;
            comp_reg       <= 1'b0;
            moved_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_x_reg      <= '0;
            out_y_reg      <= '0;
            out_moved_reg  <= 1'b0;
            wall_count_reg <= '0;
            reach_reg      <= REACH_W'(2560);
        end
        else
        begin
            if (psel && penable && pwrite)
            begin
                if (paddr[2] == REG_REACH)
                    reach_reg <= pwdata[REACH_W-1:0];
                else
                    wall_count_reg <= pwdata[COUNT_W-1:0];
            end
            if (out_valid_reg && results.ready && state_reg != ST_DONE)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept && items.mode)
                    begin
                        moved_reg <= 1'b0;
                        rot_reg   <= '0;
                        state_reg <= ST_RR;
                    end
                end
                ST_RR:    state_reg <= ST_WALL;
                ST_WALL:
                begin
                    if (CMPW'(rot_reg) < CMPW'(wall_count_reg))
                        state_reg <= ST_D1;
                    else
                        state_reg <= ST_NEXT;
                end
                ST_D1:    state_reg <= ST_D2;
                ST_D2:    state_reg <= ST_L1;
                ST_L1:    state_reg <= ST_L2;
                ST_L2:
                begin
                    comp_reg  <= 1'b0;
                    state_reg <= ST_PM0;
                end
                ST_PM0:   state_reg <= (len2_reg == '0) ? ST_CLAMP : ST_PM1;
                ST_PM1:   state_reg <= ST_PM2;
                ST_PM2:   state_reg <= ST_PDIV;
                ST_PDIV:
                begin
                    if (!div_busy)
                    begin
                        if (comp_reg)
                            state_reg <= ST_CLAMP;
                        else
                        begin
                            comp_reg  <= 1'b1;
                            state_reg <= ST_PM0;
                        end
                    end
                end
                ST_CLAMP: state_reg <= ST_DD0;
                ST_DD0:   state_reg <= ST_DD1;
                ST_DD1:   state_reg <= ST_DD2;
                ST_DD2:   state_reg <= ST_TEST;
                ST_TEST:
                begin
                    if (pushed)
                    begin
                        moved_reg <= 1'b1;
                        state_reg <= (d2_reg == '0) ? ST_NEXT : ST_SQRT;
                    end
                    else
                        state_reg <= ST_NEXT;
                end
                ST_SQRT:
                begin
                    if (!sqrt_busy)
                    begin
                        comp_reg  <= 1'b0;
                        state_reg <= ST_QM;
                    end
                end
                ST_QM:    state_reg <= ST_QD;
                ST_QD:    state_reg <= ST_QW;
                ST_QW:
                begin
                    if (!div_busy)
                    begin
                        if (comp_reg)
                            state_reg <= ST_NEXT;
                        else
                        begin
                            comp_reg  <= 1'b1;
                            state_reg <= ST_QM;
                        end
                    end
                end
                ST_NEXT:
                begin
                    if (rot_reg == RW'(MAX_WALLS - 1))
                    begin
                        rot_reg   <= '0;
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        rot_reg   <= rot_reg + 1'b1;
                        state_reg <= ST_WALL;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || results.ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_x_reg     <= px_reg;
                        out_y_reg     <= py_reg;
                        out_moved_reg <= moved_reg;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:  state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && items.mode)
                begin
                    px_reg <= items.point_x;
                    py_reg <= items.point_y;
                end
            end
            ST_RR:    rr_reg <= prod_reg[31:0];
            ST_D1:    acc_reg <= prod_reg;
            ST_D2:    dot_reg <= 43'(acc_reg + prod_reg);
            ST_L1:    acc_reg <= prod_reg;
            ST_L2:    len2_reg <= 41'(acc_reg + prod_reg);
            ST_PM0:
            begin
                if (len2_reg == '0)
                begin
                    fx_reg <= sx24;
                    fy_reg <= sy24;
                end
            end
            ST_PM1:   acc_reg <= prod_reg;
            ST_PDIV:
            begin
                if (!div_busy)
                begin
                    if (comp_reg)
                        fy_reg <= 24'(fnew25);
                    else
                        fx_reg <= 24'(fnew25);
                end
            end
            ST_CLAMP:
            begin
                dx_reg <= dx_c;
                dy_reg <= dy_c;
            end
            ST_DD1:   acc_reg <= prod_reg;
            ST_DD2:   d2_reg <= 51'(acc_reg + prod_reg);
            ST_TEST:
            begin
                if (pushed && d2_reg == '0)
                    px_reg <= sat_q(preach26);
            end
            ST_SQRT:
            begin
                if (!sqrt_busy)
                begin
                    q_reg <= root;
                    k_reg <= {1'b0, reach_reg, 8'd0} - {1'b0, root};
                end
            end
            ST_QW:
            begin
                if (!div_busy)
                begin
                    if (comp_reg)
                        py_reg <= sat_q(pnew26);
                    else
                        px_reg <= sat_q(pnew26);
                end
            end
            default:  acc_reg <= acc_reg;
        endcase
    end

    assign results.valid     = out_valid_reg;
    assign results.placed_x  = out_x_reg;
    assign results.placed_y  = out_y_reg;
    assign results.was_moved = out_moved_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_REACH) ? PDATA_W'(reach_reg) : PDATA_W'(wall_count_reg);

    `ASSERT_IMP(a_div_owner, div_busy, state_reg == ST_PDIV || state_reg == ST_QW, "stray divide")
    `ASSERT_IMP(a_sqrt_owner, sqrt_busy, state_reg == ST_SQRT, "root unit busy outside its wait")
    `ASSERT_NXT(a_place_start, accept && items.mode, state_reg == ST_RR && !moved_reg, "bad start")
    `ASSERT_IMP(a_ring_home, state_reg == ST_IDLE, rot_reg == '0, "ring not at home while idle")

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import ppos_pkg::*;

    localparam int CYCLE_LIMIT = 40000000;
    localparam int SETTLE_CYCLES = 200;

    typedef struct packed {
        logic                  mode;
        logic [IDX_W-1:0]      wall_index;
        logic [COORD_W-1:0]    start_x;
        logic [COORD_W-1:0]    start_y;
        logic [COORD_W-1:0]    end_x;
        logic [COORD_W-1:0]    end_y;
        logic signed [Q_W-1:0] point_x;
        logic signed [Q_W-1:0] point_y;
    } ppos_item_t;

    typedef struct packed {
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic                  moved;
    } placement_t;

    typedef struct {
        bit         is_cfg;
        logic       cfg_reg;
        int         cfg_value;
        ppos_item_t item;
        bit         has_exp;
        placement_t exp;
    } plan_row_t;

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic pready;

    ppos_item_if   items ();
    ppos_result_if results ();

    point_push_out_of_segments dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items.sink),
        .results (results.source),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // shadow of the block's state
    logic [COORD_W-1:0] wall_sx [MAX_WALLS_DEF];
    logic [COORD_W-1:0] wall_sy [MAX_WALLS_DEF];
    logic [COORD_W-1:0] wall_ex [MAX_WALLS_DEF];
    logic [COORD_W-1:0] wall_ey [MAX_WALLS_DEF];
    int unsigned walls_in_use;
    int unsigned reach_q8;

    placement_t pending_placements[$];
    plan_row_t  plan[$];
    int fails;
    int unsigned cycles;
    int send_idle_pct;
    int recv_idle_pct;

    always
    begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    function automatic longint round_div(input longint num, input longint den);
        longint unsigned mag;
        longint unsigned quo;
        mag = (num < 0) ? longint'(-num) : num;
        quo = (mag + longint'(den / 2)) / longint'(den);
        return (num < 0) ? -longint'(quo) : longint'(quo);
    endfunction

    function automatic longint root_floor(input longint unsigned val);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > val)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (val >= root + bitv)
            begin
                val = val - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return longint'(root);
    endfunction

    function automatic longint clip_q(input longint v);
        if (v > longint'(Q_MAX))
            return longint'(Q_MAX);
        if (v < longint'(Q_MIN))
            return longint'(Q_MIN);
        return v;
    endfunction

    function automatic placement_t push_out(input logic signed [Q_W-1:0] pt_x,
                                            input logic signed [Q_W-1:0] pt_y);
        placement_t res;
        longint px, py, sx, sy, ex, ey, vx, vy, len2, fx, fy, dot, dx, dy, d2, q, k, r;
        int unsigned n;
        px = pt_x;
        py = pt_y;
        r = reach_q8;
        res.moved = 1'b0;
        n = (walls_in_use < MAX_WALLS_DEF) ? walls_in_use : MAX_WALLS_DEF;
        for (int i = 0; i < n; i++)
        begin
            sx = longint'(wall_sx[i]) << 8;
            sy = longint'(wall_sy[i]) << 8;
            ex = longint'(wall_ex[i]) << 8;
            ey = longint'(wall_ey[i]) << 8;
            vx = ex - sx;
            vy = ey - sy;
            len2 = vx * vx + vy * vy;
            fx = sx;
            fy = sy;
            if (len2 != 0)
            begin
                dot = (px - sx) * vx + (py - sy) * vy;
                fx = sx + round_div(vx * dot, len2);
                fy = sy + round_div(vy * dot, len2);
            end
            if (fx > sx && fx > ex)
            begin
                if (sx > ex) begin fx = sx; fy = sy; end else begin fx = ex; fy = ey; end
            end
            else if (fx < sx && fx < ex)
            begin
                if (sx < ex) begin fx = sx; fy = sy; end else begin fx = ex; fy = ey; end
            end
            else if (fy > sy && fy > ey)
            begin
                if (sy > ey) begin fx = sx; fy = sy; end else begin fx = ex; fy = ey; end
            end
            else if (fy < sy && fy < ey)
            begin
                if (sy < ey) begin fx = sx; fy = sy; end else begin fx = ex; fy = ey; end
            end
            dx = px - fx;
            dy = py - fy;
            d2 = dx * dx + dy * dy;
            if (d2 < r * r)
            begin
                res.moved = 1'b1;
                if (d2 == 0)
                    px = px + r;
                else
                begin
                    q = root_floor(longint'(d2) << 16);
                    k = r * 256 - q;
                    px = px + round_div(dx * k, q);
                    py = py + round_div(dy * k, q);
                end
                px = clip_q(px);
                py = clip_q(py);
            end
        end
        res.x = px[Q_W-1:0];
        res.y = py[Q_W-1:0];
        return res;
    endfunction

    task automatic write_reg(input logic regsel, input int value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(regsel) << 2;
        pwdata  <= PDATA_W'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (regsel == REG_WALL_COUNT)
            walls_in_use = value & 8'h7f;
        else
            reach_q8 = value & 16'hffff;
    endtask

    task automatic drain_and_configure(input logic regsel, input int value);
        @(negedge clk);
        items.valid <= 1'b0;
        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        write_reg(regsel, value);
    endtask

    // leaves valid high after acceptance so back-to-back transactions need no toggle
    task automatic send_item(input ppos_item_t it, input bit has_exp, input placement_t exp);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            @(negedge clk);
            items.valid <= 1'b0;
            @(posedge clk);
        end
        @(negedge clk);
        items.valid        <= 1'b1;
        items.mode         <= it.mode;
        items.wall_index   <= it.wall_index;
        items.wall_start_x <= it.start_x;
        items.wall_start_y <= it.start_y;
        items.wall_end_x   <= it.end_x;
        items.wall_end_y   <= it.end_y;
        items.point_x      <= it.point_x;
        items.point_y      <= it.point_y;
        do
            @(posedge clk);
        while (!items.ready);
        if (it.mode == 1'b0)
        begin
            wall_sx[it.wall_index] = it.start_x;
            wall_sy[it.wall_index] = it.start_y;
            wall_ex[it.wall_index] = it.end_x;
            wall_ey[it.wall_index] = it.end_y;
        end
        else if (has_exp)
            pending_placements.push_back(exp);
        else
            pending_placements.push_back(push_out(it.point_x, it.point_y));
    endtask

    function automatic ppos_item_t wall_item(input int idx, input int sx, input int sy,
                                             input int ex, input int ey);
        ppos_item_t it;
        it = '0;
        it.mode = 1'b0;
        it.wall_index = IDX_W'(idx);
        it.start_x = COORD_W'(sx);
        it.start_y = COORD_W'(sy);
        it.end_x = COORD_W'(ex);
        it.end_y = COORD_W'(ey);
        it.point_x = Q_W'($urandom());
        it.point_y = Q_W'($urandom());
        return it;
    endfunction

    function automatic ppos_item_t point_item(input int px, input int py);
        ppos_item_t it;
        it = '0;
        it.mode = 1'b1;
        it.wall_index = IDX_W'($urandom());
        it.start_x = COORD_W'($urandom());
        it.start_y = COORD_W'($urandom());
        it.end_x = COORD_W'($urandom());
        it.end_y = COORD_W'($urandom());
        it.point_x = Q_W'(px);
        it.point_y = Q_W'(py);
        return it;
    endfunction

    function automatic int pick_coord();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel == 0)
            return 0;
        if (sel == 1)
            return 4095;
        return $urandom_range(0, 4095);
    endfunction

    function automatic ppos_item_t random_wall(input int idx);
        int sx, sy, ex, ey, sel;
        sx = pick_coord();
        sy = pick_coord();
        ex = pick_coord();
        ey = pick_coord();
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            ex = sx;
            ey = sy;
        end
        else if (sel == 1)
            ex = sx;
        else if (sel == 2)
            ey = sy;
        else if (sel < 6)
        begin
            ex = sx + $urandom_range(0, 60) - 30;
            ey = sy + $urandom_range(0, 60) - 30;
            ex = (ex < 0) ? 0 : (ex > 4095) ? 4095 : ex;
            ey = (ey < 0) ? 0 : (ey > 4095) ? 4095 : ey;
        end
        return wall_item(idx, sx, sy, ex, ey);
    endfunction

    // mostly points dropped close to a visited wall, the rest noise and extremes
    function automatic ppos_item_t random_point();
        int n, w, sel, t, spread;
        longint bx, by;
        logic [31:0] raw_x, raw_y;
        n = (walls_in_use < MAX_WALLS_DEF) ? walls_in_use : MAX_WALLS_DEF;
        sel = $urandom_range(0, 99);
        raw_x = $urandom();
        raw_y = $urandom();
        if (n == 0 || sel < 15)
            return point_item(int'($signed(raw_x[Q_W-1:0])), int'($signed(raw_y[Q_W-1:0])));
        if (sel < 20)
            return point_item($urandom_range(0, 1) ? int'(Q_MAX) : int'(Q_MIN),
                              $urandom_range(0, 1) ? int'(Q_MAX) : int'(Q_MIN));
        w = $urandom_range(0, n - 1);
        t = $urandom_range(0, 256);
        bx = (longint'(wall_sx[w]) << 8) + (longint'(wall_ex[w]) - wall_sx[w]) * t;
        by = (longint'(wall_sy[w]) << 8) + (longint'(wall_ey[w]) - wall_sy[w]) * t;
        if (sel < 30)
            return point_item(int'(bx), int'(by));
        spread = reach_q8 + reach_q8 / 2 + 16;
        bx = bx + int'($urandom_range(0, 2 * spread)) - spread;
        by = by + int'($urandom_range(0, 2 * spread)) - spread;
        return point_item(int'(clip_q(bx)), int'(clip_q(by)));
    endfunction

    function automatic plan_row_t row_of(input ppos_item_t it);
        plan_row_t row;
        row = '{default: '0};
        row.item = it;
        return row;
    endfunction

    function automatic plan_row_t row_checked(input ppos_item_t it, input int ex,
                                              input int ey, input bit moved);
        plan_row_t row;
        row = row_of(it);
        row.has_exp = 1'b1;
        row.exp.x = Q_W'(ex);
        row.exp.y = Q_W'(ey);
        row.exp.moved = moved;
        return row;
    endfunction

    function automatic plan_row_t row_cfg(input logic regsel, input int value);
        plan_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.cfg_reg = regsel;
        row.cfg_value = value;
        return row;
    endfunction

    always @(negedge clk)
        results.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && results.valid && results.ready)
        begin
            if (pending_placements.size() == 0)
            begin
                $error("unexpected transaction: x=%0d y=%0d moved=%0b",
                       results.placed_x, results.placed_y, results.was_moved);
                fails++;
            end
            else
            begin
                placement_t exp;
                exp = pending_placements.pop_front();
                if (results.placed_x !== exp.x)
                begin
                    $error("placed_x: expected %0d, got %0d", exp.x, results.placed_x);
                    fails++;
                end
                if (results.placed_y !== exp.y)
                begin
                    $error("placed_y: expected %0d, got %0d", exp.y, results.placed_y);
                    fails++;
                end
                if (results.was_moved !== exp.moved)
                begin
                    $error("was_moved: expected %0b, got %0b", exp.moved, results.was_moved);
                    fails++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        int sent;
        int phase_count [7] = '{2, 5, 127, 8, 4, 64, 6};
        int phase_reach [7] = '{2560, 0, 65535, 1, 4000, 300, 2560};
        int phase_items [7] = '{100, 60, 20, 100, 100, 20, 100};
        placement_t none;

        none = '0;
        fails = 0;
        cycles = 0;
        sent = 0;
        send_idle_pct = 24;
        recv_idle_pct = 53;
        walls_in_use = 0;
        reach_q8 = 2560;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        results.ready = 1'b0;
        items.valid = 1'b0;
        items.mode = 1'b0;
        items.wall_index = '0;
        items.wall_start_x = '0;
        items.wall_start_y = '0;
        items.wall_end_x = '0;
        items.wall_end_y = '0;
        items.point_x = '0;
        items.point_y = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // no walls visited after reset: the point comes back untouched
        plan.push_back(row_checked(point_item(0, 0), 0, 0, 1'b0));
        plan.push_back(row_checked(point_item(int'(Q_MAX), int'(Q_MIN)),
                                   int'(Q_MAX), int'(Q_MIN), 1'b0));
        plan.push_back(row_of(wall_item(0, 0, 0, 4095, 0)));
        plan.push_back(row_of(wall_item(1, 100, 100, 100, 100)));
        plan.push_back(row_of(wall_item(2, 4095, 4095, 4095, 0)));
        plan.push_back(row_of(wall_item(3, 10, 20, 30, 5)));
        plan.push_back(row_cfg(REG_WALL_COUNT, 4));
        plan.push_back(row_of(point_item(50 * 256, 0)));
        plan.push_back(row_of(point_item(100 * 256, 100 * 256)));
        plan.push_back(row_of(point_item(101 * 256, 99 * 256 + 7)));
        plan.push_back(row_checked(point_item(int'(Q_MIN), int'(Q_MIN)),
                                   int'(Q_MIN), int'(Q_MIN), 1'b0));
        plan.push_back(row_of(point_item(-300, -300)));
        plan.push_back(row_of(point_item(20 * 256, 12 * 256 + 100)));
        plan.push_back(row_of(point_item(35 * 256, 0)));
        plan.push_back(row_cfg(REG_REACH, 65535));
        plan.push_back(row_of(point_item(int'(Q_MAX), 2000 * 256)));
        plan.push_back(row_of(point_item(4095 * 256 - 10, 4095 * 256)));
        plan.push_back(row_of(point_item(4095 * 256, 4095 * 256)));
        plan.push_back(row_cfg(REG_REACH, 0));
        plan.push_back(row_checked(point_item(50 * 256, 0), 50 * 256, 0, 1'b0));
        plan.push_back(row_cfg(REG_REACH, 2560));

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
                drain_and_configure(plan[i].cfg_reg, plan[i].cfg_value);
            else
            begin
                send_item(plan[i].item, plan[i].has_exp, plan[i].exp);
                sent++;
            end
        end

        // fill the whole table so any wall_count is legal from here on
        for (int i = 0; i < MAX_WALLS_DEF; i++)
        begin
            send_item(random_wall(i), 1'b0, none);
            sent++;
        end

        for (int p = 0; p < 7; p++)
        begin
            drain_and_configure(REG_WALL_COUNT, phase_count[p]);
            drain_and_configure(REG_REACH, phase_reach[p]);
            for (int i = 0; i < phase_items[p]; i++)
            begin
                if (sent >= 380)
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
                else if (sent >= 190)
                begin
                    send_idle_pct = 53;
                    recv_idle_pct = 24;
                end
                if ($urandom_range(0, 99) < 25)
                    send_item(random_wall($urandom_range(0, MAX_WALLS_DEF - 1)), 1'b0, none);
                else
                    send_item(random_point(), 1'b0, none);
                sent++;
            end
        end
        @(negedge clk);
        items.valid <= 1'b0;

        while (pending_placements.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fails == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+src
src/ppos_pkg.sv
src/ppos_channels.sv
src/ppos_cell.sv
src/ppos_div.sv
src/ppos_sqrt.sv
src/point_push_out_of_segments.sv
dv/testbench.sv
